@@ hw/rtl/icfs_pkg.sv @@
// Shared widths, codes and control/status types of the inverse-CDF frequency sampler.
`default_nettype none

package icfs_pkg;

  localparam int unsigned BASE_W    = 54;
  localparam int unsigned STEP_W    = 48;
  localparam int unsigned CDF_W     = 32;
  localparam int unsigned ENTRY_W   = 8;
  localparam int unsigned FREQ_W    = 56;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned CFG_W     = 54;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BASE_W-1:0] BASE_RESET = 54'd3289000000000000;
  localparam logic [STEP_W-1:0] STEP_RESET = 48'd38694117647059;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FREQ = 1'b0,
    CFG_FREQ_STEP = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RD_MID = 2'd0,
    RD_LO  = 2'd1,
    RD_LO1 = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic    wr_entry;
    logic    init_search;
    logic    search_step;
    rd_src_e rd_src;
    logic    cap_c0;
    logic    cap_c1;
    logic    prep_div;
    logic    div_step;
    logic    add_sum;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic flat;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/icfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module icfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/icfs_ctrl.sv @@
// Sequencer: search, table reads, serial division, sum and result hand-off.
`default_nettype none

module icfs_ctrl #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              opcode_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output icfs_pkg::cmd_t         cmd_o,
  input  wire icfs_pkg::status_t sts_i
);

  localparam int unsigned CNT_W = $clog2(FRACTION_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_RDC0,
    S_RDC1,
    S_PREP,
    S_DIV,
    S_SUM,
    S_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  icfs_pkg::cmd_t   cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd         = '0;
    cmd.rd_src  = icfs_pkg::RD_MID;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == icfs_pkg::OP_SAMPLE) begin
            cmd.init_search = 1'b1;
            state_d         = S_SRCH;
          end else begin
            cmd.wr_entry = 1'b1;
          end
        end
      end
      S_SRCH: begin
        if (sts_i.search_done) begin
          cmd.rd_src = icfs_pkg::RD_LO;
          state_d    = S_RDC0;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd.search_step = 1'b1;
        state_d         = S_SRCH;
      end
      S_RDC0: begin
        cmd.cap_c0 = 1'b1;
        cmd.rd_src = icfs_pkg::RD_LO1;
        state_d    = S_RDC1;
      end
      S_RDC1: begin
        cmd.cap_c1 = 1'b1;
        state_d    = S_PREP;
      end
      S_PREP: begin
        if (sts_i.flat) begin
          state_d = S_SUM;
        end else begin
          cmd.prep_div = 1'b1;
          cnt_d        = CNT_W'(FRACTION_BITS - 1);
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SUM;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_SUM: begin
        cmd.add_sum = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        // output register must be empty or draining this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

@@ hw/rtl/icfs_datapath.sv @@
// Datapath: CDF table, search bounds, divider with step accumulation, output registers.
`default_nettype none

module icfs_datapath #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [icfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [icfs_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic [icfs_pkg::ENTRY_W-1:0]      entry_index_i,
  input  wire logic [icfs_pkg::CDF_W-1:0]        entry_value_i,
  input  wire logic [icfs_pkg::CDF_W-1:0]        uniform_value_i,
  input  wire icfs_pkg::cmd_t                    cmd_i,
  output icfs_pkg::status_t                      sts_o,
  output logic      [icfs_pkg::FREQ_W-1:0]       frequency_o,
  output logic      [icfs_pkg::BIN_W-1:0]        bin_found_o,
  output logic                                   flat_bin_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned STEP_W = icfs_pkg::STEP_W;
  localparam int unsigned BASE_W = icfs_pkg::BASE_W;
  localparam int unsigned CDF_W  = icfs_pkg::CDF_W;
  localparam int unsigned FREQ_W = icfs_pkg::FREQ_W;
  localparam int unsigned PROD_W = STEP_W + IDX_W;
  localparam int unsigned LOW_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
  localparam int unsigned SUM_W  = LOW_W + 1;
  localparam int unsigned ACC_W  = STEP_W + FRACTION_BITS + 1;
  localparam int unsigned OFF_W  = STEP_W + 1;

  logic [BASE_W-1:0] base_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= icfs_pkg::BASE_RESET;
      step_q <= icfs_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        icfs_pkg::CFG_BASE_FREQ: base_q <= cfg_data_i[BASE_W-1:0];
        icfs_pkg::CFG_FREQ_STEP: step_q <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  // table
  logic [IDX_W-1:0] lo_q, hi_q;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid, span, raddr;
  logic [CDF_W-1:0] rdata;
  logic             wr_en;

  assign wr_en   = cmd_i.wr_entry && (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];
  assign span    = hi_q - lo_q;

  always_comb begin
    unique case (cmd_i.rd_src)
      icfs_pkg::RD_LO:  raddr = lo_q;
      icfs_pkg::RD_LO1: raddr = lo_q + IDX_W'(1);
      default:          raddr = mid;
    endcase
  end

  icfs_ram #(
    .WIDTH (CDF_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cdf_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // search and interpolation registers
  logic [CDF_W-1:0]  u_q, c0_q, num_q, den_q, rem_q;
  logic              flat_q;
  logic [PROD_W-1:0] prod_q;
  logic [LOW_W-1:0]  lower_q;
  logic [ACC_W-1:0]  acc_q;
  logic [SUM_W-1:0]  sum_q;

  logic [CDF_W:0]    rem_sh;
  logic              rem_ge;
  logic [OFF_W-1:0]  offset;

  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign offset = acc_q[ACC_W-1:FRACTION_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_search) begin
      u_q  <= uniform_value_i;
      lo_q <= '0;
      hi_q <= IDX_W'(TABLE_DEPTH - 1);
    end
    if (cmd_i.search_step) begin
      if (rdata <= u_q) begin
        lo_q <= mid;
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.cap_c0) begin
      c0_q   <= rdata;
      num_q  <= (u_q > rdata) ? (u_q - rdata) : '0;
      prod_q <= PROD_W'(lo_q) * PROD_W'(step_q);
    end
    if (cmd_i.cap_c1) begin
      den_q   <= rdata - c0_q;
      flat_q  <= (rdata <= c0_q);
      lower_q <= LOW_W'(base_q) + LOW_W'(prod_q);
    end
    // leading quotient bit: num saturated to den gives exactly one
    if (cmd_i.prep_div) begin
      if (num_q >= den_q) begin
        rem_q <= '0;
        acc_q <= ACC_W'(step_q);
      end else begin
        rem_q <= num_q;
        acc_q <= '0;
      end
    end
    // restoring step; acc tracks step * quotient so far
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? CDF_W'(rem_sh - {1'b0, den_q}) : rem_sh[CDF_W-1:0];
      acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (rem_ge ? ACC_W'(step_q) : '0);
    end
    if (cmd_i.add_sum) begin
      sum_q <= SUM_W'(lower_q) + (flat_q ? '0 : SUM_W'(offset));
    end
  end

  logic [FREQ_W-1:0]         freq_q;
  logic [icfs_pkg::BIN_W-1:0] bin_q;
  logic                      flat_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      freq_q     <= (sum_q > SUM_W'(icfs_pkg::FREQ_MAX)) ? icfs_pkg::FREQ_MAX
                                                          : sum_q[FREQ_W-1:0];
      bin_q      <= icfs_pkg::BIN_W'(lo_q);
      flat_out_q <= flat_q;
    end
  end

  assign sts_o.search_done = (span <= IDX_W'(1));
  assign sts_o.flat        = flat_q;
  assign frequency_o       = freq_q;
  assign bin_found_o       = bin_q;
  assign flat_bin_o        = flat_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/inverse_cdf_frequency_sampler_unit.sv @@
// Top level of the inverse-CDF frequency sampler: controller, datapath and checks.
//
// Input channel (valid/ready): opcode 0 writes entry_value into the CDF table at
// entry_index (indexes past the table are dropped) and produces no result; the
// sequencer stays idle. Opcode 1 draws a sample from uniform_value and produces one
// result transaction (frequency, bin_found, flat_bin) on the output channel.
// A sample's result becomes valid as the sequencer returns to idle, so the next
// item can be accepted as soon as the result is valid. A sample's run is set by
// the binary search, which needs one table RAM read and one compare per step, and
// by the radix-2 divider, one quotient bit per cycle. A flat bin skips the divider.
// Input ready is high only while the sequencer is idle. The result sits in an
// output register: the next item is accepted while it waits, and a later sample
// stalls only in its last step until the receiver takes the pending result.
// Reset sets base_frequency and frequency_step to their defaults and empties
// the output register; table contents are undefined until loaded.
// Configuration writes (cfg_we_i) take effect at once; the user must make them
// only while idle, and the block itself does not enforce this.
`default_nettype none

module inverse_cdf_frequency_sampler_unit #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [icfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [icfs_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           opcode_i,
  input  wire logic [icfs_pkg::ENTRY_W-1:0]   entry_index_i,
  input  wire logic [icfs_pkg::CDF_W-1:0]     entry_value_i,
  input  wire logic [icfs_pkg::CDF_W-1:0]     uniform_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [icfs_pkg::FREQ_W-1:0]    frequency_o,
  output logic      [icfs_pkg::BIN_W-1:0]     bin_found_o,
  output logic                                flat_bin_o
);

  icfs_pkg::cmd_t    cmd;
  icfs_pkg::status_t sts;

  icfs_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  icfs_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .uniform_value_i (uniform_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frequency_o     (frequency_o),
    .bin_found_o     (bin_found_o),
    .flat_bin_o      (flat_bin_o)
  );

  // a new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten while stalled");

  // an accepted sample keeps the block busy on the next cycle
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == icfs_pkg::OP_SAMPLE)) |=> !in_ready_o)
    else $error("sample accepted without leaving idle");

  // table writes only happen on an accepted load transaction
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_entry |-> (in_valid_i && in_ready_o && (opcode_i == icfs_pkg::OP_LOAD)))
    else $error("table write outside a load transaction");

endmodule

`default_nettype wire

@@ test/tb_inverse_cdf_frequency_sampler_unit.sv @@
// Self-checking testbench for the inverse-CDF frequency sampler: table loads, draws, grid settings.
module tb_inverse_cdf_frequency_sampler_unit;
  import icfs_pkg::*;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned FRAC_BITS     = 32;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic               op;
    logic [ENTRY_W-1:0] idx;
    logic [CDF_W-1:0]   val;
    logic [CDF_W-1:0]   u;
  } sampler_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [BIN_W-1:0]  bin;
    logic              flat;
  } draw_result_t;

  typedef enum {TBL_RAMP, TBL_PEAK, TBL_LEVEL, TBL_NOISE} table_shape_e;

  // Mirrors the grid settings and CDF table; predicts each draw and checks it on return.
  class draw_checker;
    logic [BASE_W-1:0] base_freq;
    logic [STEP_W-1:0] freq_step;
    logic [CDF_W-1:0]  cdf_tab[DEPTH];
    draw_result_t      pending_draws[$];
    int unsigned       mismatches;

    function new();
      base_freq  = BASE_RESET;
      freq_step  = STEP_RESET;
      mismatches = 0;
      foreach (cdf_tab[k]) cdf_tab[k] = '0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CFG_W-1:0] d);
      if (r == CFG_BASE_FREQ) base_freq = d[BASE_W-1:0];
      else freq_step = d[STEP_W-1:0];
    endfunction

    function void note_item(sampler_item_t it);
      int unsigned lo, hi, mid;
      logic [63:0] u, c0, c1, lower, den, num, frac, freq;
      logic [111:0] scaled;
      draw_result_t r;
      if (it.op == OP_LOAD) begin
        cdf_tab[it.idx] = it.val;
        return;
      end
      u  = 64'(it.u);
      lo = 0;
      hi = DEPTH - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (64'(cdf_tab[mid]) <= u) lo = mid;
        else hi = mid;
      end
      c0     = 64'(cdf_tab[lo]);
      c1     = 64'(cdf_tab[lo + 1]);
      lower  = 64'(base_freq) + 64'(lo) * 64'(freq_step);
      r.flat = (c1 <= c0);
      freq   = lower;
      if (!r.flat) begin
        den = c1 - c0;
        num = (u > c0) ? u - c0 : 64'd0;
        if (num > den) num = den;
        // truncating quotient, 0..2^FRAC_BITS
        frac   = (num << FRAC_BITS) / den;
        scaled = 112'(freq_step) * 112'(frac);
        freq   = lower + 64'(scaled >> FRAC_BITS);
      end
      r.freq = (freq > 64'(FREQ_MAX)) ? FREQ_MAX : freq[FREQ_W-1:0];
      r.bin  = BIN_W'(lo);
      pending_draws.push_back(r);
    endfunction

    function void check_draw(logic [FREQ_W-1:0] freq, logic [BIN_W-1:0] bin, logic flat);
      draw_result_t exp_r;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected draw: freq=%0d bin=%0d flat=%0b", freq, bin, flat);
        return;
      end
      exp_r = pending_draws.pop_front();
      if (freq !== exp_r.freq || bin !== exp_r.bin || flat !== exp_r.flat) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("draw mismatch: freq exp %0d got %0d, bin exp %0d got %0d, flat exp %0b got %0b",
                   exp_r.freq, freq, exp_r.bin, bin, exp_r.flat, flat);
      end
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_BASE_FREQ;
  logic [CFG_W-1:0]   cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               opcode_i        = OP_LOAD;
  logic [ENTRY_W-1:0] entry_index_i   = '0;
  logic [CDF_W-1:0]   entry_value_i   = '0;
  logic [CDF_W-1:0]   uniform_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [FREQ_W-1:0]  frequency_o;
  logic [BIN_W-1:0]   bin_found_o;
  logic               flat_bin_o;

  draw_checker sb = new();
  int unsigned idle_pct      = 30;
  int unsigned stall_request = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;

  inverse_cdf_frequency_sampler_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .uniform_value_i(uniform_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frequency_o    (frequency_o),
    .bin_found_o    (bin_found_o),
    .flat_bin_o     (flat_bin_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each transaction, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_draw(frequency_o, bin_found_o, flat_bin_o);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic sampler_item_t load_item(logic [ENTRY_W-1:0] idx, logic [CDF_W-1:0] val);
    sampler_item_t it;
    it.op  = OP_LOAD;
    it.idx = idx;
    it.val = val;
    it.u   = $urandom;
    return it;
  endfunction

  function automatic sampler_item_t draw_item(logic [CDF_W-1:0] u);
    sampler_item_t it;
    it.op  = OP_SAMPLE;
    it.idx = ENTRY_W'($urandom);
    it.val = $urandom;
    it.u   = u;
    return it;
  endfunction

  function automatic logic [CDF_W-1:0] pick_uniform();
    int unsigned r;
    logic [CDF_W-1:0] near;
    r    = $urandom_range(99);
    near = sb.cdf_tab[$urandom_range(DEPTH - 1)] + CDF_W'($urandom_range(4)) - CDF_W'(2);
    if (r < 55) return $urandom;
    else if (r < 80) return near;
    else if (r < 85) return CDF_W'($urandom_range(255));
    else if (r < 90) return ~CDF_W'($urandom_range(255));
    else if (r < 95) return '0;
    else return '1;
  endfunction

  task automatic send_item(sampler_item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= it.op;
    entry_index_i   <= it.idx;
    entry_value_i   <= it.val;
    uniform_value_i <= it.u;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  // Loads produce no transaction, so let the sequencer run out before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] base, logic [CFG_W-1:0] step);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BASE_FREQ;
    cfg_data_i  <= base;
    @(posedge clk_i);
    sb.set_reg(CFG_BASE_FREQ, base);
    cfg_index_i <= CFG_FREQ_STEP;
    cfg_data_i  <= step;
    @(posedge clk_i);
    sb.set_reg(CFG_FREQ_STEP, step);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic fill_table(table_shape_e shape);
    logic [63:0] acc;
    int unsigned peak;
    logic [CDF_W-1:0] level, v;
    acc   = 64'($urandom_range(1 << 20, 1));
    peak  = $urandom_range(DEPTH - 10);
    level = $urandom;
    for (int k = 0; k < DEPTH; k++) begin
      case (shape)
        TBL_RAMP: begin
          v = (acc > 64'hFFFF_FFFF) ? '1 : acc[CDF_W-1:0];
          // occasional zero step leaves a flat bin
          if ($urandom_range(9) != 0) acc += 64'($urandom_range(1 << 25));
        end
        TBL_PEAK: begin
          if (k < peak) v = '0;
          else if (k < peak + 8) v = CDF_W'(k - peak + 1) * 32'h1FFF_FFFF;
          else v = 32'hFFFF_FFFF - CDF_W'($urandom_range(3));
        end
        TBL_LEVEL: v = level;
        default:   v = $urandom;
      endcase
      send_item(load_item(ENTRY_W'(k), v));
    end
  endtask

  task automatic run_mix(int unsigned n);
    int unsigned k, r;
    logic [CDF_W-1:0] lo_v, hi_v, v;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_item(draw_item(pick_uniform()));
      end else begin
        k    = $urandom_range(DEPTH - 1);
        lo_v = (k > 0) ? sb.cdf_tab[k - 1] : '0;
        hi_v = (k < DEPTH - 1) ? sb.cdf_tab[k + 1] : '1;
        r    = $urandom_range(99);
        if (r < 70 && lo_v <= hi_v) v = $urandom_range(hi_v, lo_v);
        else if (r < 85) v = lo_v;
        else v = $urandom;
        send_item(load_item(ENTRY_W'(k), v));
      end
    end
  endtask

  initial begin
    table_shape_e shape;
    int unsigned mix_len;
    bit refill;
    shape   = TBL_RAMP;
    mix_len = 0;
    refill  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every entry written before the first draw
    fill_table(TBL_RAMP);
    send_item(draw_item('0));                    // below the first entry
    send_item(draw_item('1));                    // past the last entry, clamped bin
    send_item(draw_item(sb.cdf_tab[100]));
    send_item(draw_item(sb.cdf_tab[100] - 1));
    send_item(draw_item(sb.cdf_tab[254]));
    send_item(draw_item(sb.cdf_tab[1]));
    send_item(draw_item(32'h8000_0000));
    send_item(load_item(8'd255, sb.cdf_tab[254])); // flat last bin
    send_item(draw_item('1));
    send_item(load_item(8'd255, '0));              // falling last bin
    send_item(draw_item('1));
    send_item(draw_item(32'h4000_0000));
    send_item(load_item(8'd255, '1));
    drain();
    write_grid('1, '1);                            // top of grid overflows 56 bits
    send_item(draw_item('1));
    send_item(draw_item('0));
    send_item(draw_item(32'hC000_0000));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          // keeps the directed ramp table
          write_grid(CFG_W'(BASE_RESET), CFG_W'(STEP_RESET));
          shape   = TBL_RAMP;
          refill  = 1'b0;
          mix_len = 110;
        end
        1: begin
          // step gets junk above bit 47
          write_grid(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}));
          shape   = TBL_PEAK;
          refill  = 1'b1;
          mix_len = 90;
        end
        2: begin
          write_grid('0, CFG_W'(48'hFFFF_FFFF_FFFF));
          shape   = TBL_RAMP;
          refill  = 1'b0;
          mix_len = 80;
        end
        3: begin
          write_grid('1, '1);
          shape   = TBL_NOISE;
          refill  = 1'b1;
          mix_len = 80;
        end
        4: begin
          write_grid(CFG_W'({$urandom, $urandom}), '0);
          shape   = TBL_LEVEL;
          refill  = 1'b1;
          mix_len = 60;
        end
        default: begin
          write_grid(CFG_W'({$urandom, $urandom}), CFG_W'($urandom));
          shape   = TBL_RAMP;
          refill  = 1'b1;
          mix_len = 100;
        end
      endcase
      idle_pct = (ph == 1) ? 0 : 30;
      if (refill) fill_table(shape);
      // long result-side hold so the block backs up into the input
      if (ph == 0) stall_request = 3000;
      run_mix(mix_len);
    end
    drain();

    if (sb.mismatches == 0 && sb.pending_draws.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.pending_draws.size() != 0)
        $display("%0d draws never returned", sb.pending_draws.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
